// ===== hdl/kcpd_pkg.sv =====
// ---------------------------------------------------------------------------
// Key combo classifier package
// Shared types, register indexes, action codes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package kcpd_pkg;

   localparam int MASK_BITS_DEFAULT = 16;
   localparam int KEY_W             = 16;
   localparam int TICK_W            = 16;
   localparam int CSR_ADDR_W        = 3;
   localparam int NUM_ACTIONS       = 3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MODE_COMBO = 3'd0,
      REG_SELL_COMBO = 3'd1,
      REG_TEST_COMBO = 3'd2,
      REG_MODE_SHORT = 3'd3,
      REG_MODE_LONG  = 3'd4,
      REG_SELL_HOLD  = 3'd5,
      REG_TEST_HOLD  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_MODE = 2'd0,
      ACT_SELL = 2'd1,
      ACT_TEST = 2'd2
   } action_type;

   typedef enum logic {
      FUNC_TICK  = 1'b0,
      FUNC_PAUSE = 1'b1
   } func_type;

   localparam logic PERIOD_SHORT = 1'b0;
   localparam logic PERIOD_LONG  = 1'b1;

   localparam logic [KEY_W-1:0]  MODE_COMBO_RESET = 16'd1;
   localparam logic [KEY_W-1:0]  SELL_COMBO_RESET = 16'd2;
   localparam logic [KEY_W-1:0]  TEST_COMBO_RESET = 16'd3;
   localparam logic [TICK_W-1:0] MODE_SHORT_RESET = 16'd50;
   localparam logic [TICK_W-1:0] MODE_LONG_RESET  = 16'd400;
   localparam logic [TICK_W-1:0] SELL_HOLD_RESET  = 16'd50;
   localparam logic [TICK_W-1:0] TEST_HOLD_RESET  = 16'd200;

   typedef struct packed {
      func_type          func;
      logic [KEY_W-1:0]  key_mask;
      logic [TICK_W-1:0] pause_ticks;
   } item_type;

   typedef struct packed {
      logic [TICK_W-1:0] mode_short;
      logic [TICK_W-1:0] mode_long;
      logic [TICK_W-1:0] sell_hold;
      logic [TICK_W-1:0] test_hold;
   } thresh_type;

   typedef struct packed {
      logic       detected;
      action_type action_id;
      logic       period_index;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/kcpd_csr.sv =====
// ---------------------------------------------------------------------------
// Key combo classifier register file
// Holds the three combo masks and the four hold thresholds.
// ---------------------------------------------------------------------------
`default_nettype none

module kcpd_csr #(
   parameter int MASK_BITS = kcpd_pkg::MASK_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [kcpd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [kcpd_pkg::TICK_W-1:0]     csr_wdata,
   output logic [kcpd_pkg::NUM_ACTIONS-1:0][MASK_BITS-1:0] combo_mask,
   output kcpd_pkg::thresh_type                 thresh
);

   logic [kcpd_pkg::NUM_ACTIONS-1:0][MASK_BITS-1:0] combo_ff;
   kcpd_pkg::thresh_type                            thresh_ff;
   logic                                            wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         combo_ff[kcpd_pkg::ACT_MODE] <= kcpd_pkg::MODE_COMBO_RESET[MASK_BITS-1:0];
         combo_ff[kcpd_pkg::ACT_SELL] <= kcpd_pkg::SELL_COMBO_RESET[MASK_BITS-1:0];
         combo_ff[kcpd_pkg::ACT_TEST] <= kcpd_pkg::TEST_COMBO_RESET[MASK_BITS-1:0];
         thresh_ff.mode_short <= kcpd_pkg::MODE_SHORT_RESET;
         thresh_ff.mode_long  <= kcpd_pkg::MODE_LONG_RESET;
         thresh_ff.sell_hold  <= kcpd_pkg::SELL_HOLD_RESET;
         thresh_ff.test_hold  <= kcpd_pkg::TEST_HOLD_RESET;
      end else if (wr_en) begin
         // Writes to an index past the last register are dropped.
         case (kcpd_pkg::csr_index_type'(csr_addr))
            kcpd_pkg::REG_MODE_COMBO: combo_ff[kcpd_pkg::ACT_MODE] <= csr_wdata[MASK_BITS-1:0];
            kcpd_pkg::REG_SELL_COMBO: combo_ff[kcpd_pkg::ACT_SELL] <= csr_wdata[MASK_BITS-1:0];
            kcpd_pkg::REG_TEST_COMBO: combo_ff[kcpd_pkg::ACT_TEST] <= csr_wdata[MASK_BITS-1:0];
            kcpd_pkg::REG_MODE_SHORT: thresh_ff.mode_short <= csr_wdata;
            kcpd_pkg::REG_MODE_LONG:  thresh_ff.mode_long  <= csr_wdata;
            kcpd_pkg::REG_SELL_HOLD:  thresh_ff.sell_hold  <= csr_wdata;
            kcpd_pkg::REG_TEST_HOLD:  thresh_ff.test_hold  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign combo_mask = combo_ff;
   assign thresh     = thresh_ff;

endmodule

`default_nettype wire

// ===== hdl/kcpd_core.sv =====
// ---------------------------------------------------------------------------
// Key combo classifier core
// Holds the hold count, selected action and dead time, and classifies one
// item per step.
// ---------------------------------------------------------------------------
`default_nettype none

module kcpd_core #(
   parameter int MASK_BITS = kcpd_pkg::MASK_BITS_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        step,
   input  wire kcpd_pkg::item_type                          item,
   input  wire logic [kcpd_pkg::NUM_ACTIONS-1:0][MASK_BITS-1:0] combo_mask,
   input  wire kcpd_pkg::thresh_type                        thresh,
   output kcpd_pkg::result_type                             result
);

   logic [kcpd_pkg::TICK_W-1:0] hold_count_ff, hold_count_in;
   kcpd_pkg::action_type        current_action_ff, current_action_in;
   logic [kcpd_pkg::TICK_W-1:0] dead_time_left_ff, dead_time_left_in;

   logic [kcpd_pkg::NUM_ACTIONS-1:0] match;
   logic                             any_match;
   logic                             multi_match;
   kcpd_pkg::action_type             last_match;
   logic [kcpd_pkg::TICK_W-1:0]      count_inc;
   logic [kcpd_pkg::TICK_W-1:0]      last_thresh;
   logic [kcpd_pkg::TICK_W-1:0]      first_thresh;
   logic                             above_first;
   logic                             above_long;

   always_comb begin
      for (int a = 0; a < kcpd_pkg::NUM_ACTIONS; a++) begin
         match[a] = (item.key_mask[MASK_BITS-1:0] == combo_mask[a]);
      end
   end

   assign any_match   = |match;
   assign multi_match = (match[0] & match[1]) | (match[0] & match[2]) | (match[1] & match[2]);

   // The combos are tried in order, so the last matching one wins.
   always_comb begin
      if (match[kcpd_pkg::ACT_TEST]) begin
         last_match = kcpd_pkg::ACT_TEST;
      end else if (match[kcpd_pkg::ACT_SELL]) begin
         last_match = kcpd_pkg::ACT_SELL;
      end else begin
         last_match = kcpd_pkg::ACT_MODE;
      end
   end

   // With several matches the selection changes at least once and the count
   // restarts; with one match it restarts only on a change of action.
   assign count_inc = (!multi_match && current_action_ff == last_match) ?
                      hold_count_ff + 16'd1 : 16'd1;

   always_comb begin
      case (last_match)
         kcpd_pkg::ACT_MODE: last_thresh = thresh.mode_long;
         kcpd_pkg::ACT_SELL: last_thresh = thresh.sell_hold;
         default:            last_thresh = thresh.test_hold;
      endcase
   end

   always_comb begin
      case (current_action_ff)
         kcpd_pkg::ACT_MODE: first_thresh = thresh.mode_short;
         kcpd_pkg::ACT_SELL: first_thresh = thresh.sell_hold;
         default:            first_thresh = thresh.test_hold;
      endcase
   end

   assign above_first = first_thresh < hold_count_ff;
   assign above_long  = (current_action_ff == kcpd_pkg::ACT_MODE) &&
                        (thresh.mode_long < hold_count_ff);

   always_comb begin
      hold_count_in      = hold_count_ff;
      current_action_in  = current_action_ff;
      dead_time_left_in  = dead_time_left_ff;
      result.detected     = 1'b0;
      result.action_id    = kcpd_pkg::ACT_MODE;
      result.period_index = kcpd_pkg::PERIOD_SHORT;
      if (item.func == kcpd_pkg::FUNC_PAUSE) begin
         hold_count_in     = '0;
         dead_time_left_in = item.pause_ticks;
      end else if (dead_time_left_ff != '0) begin
         dead_time_left_in = dead_time_left_ff - 16'd1;
      end else if (any_match) begin
         current_action_in = last_match;
         hold_count_in     = count_inc;
         if (count_inc >= last_thresh) begin
            result.detected     = 1'b1;
            result.action_id    = last_match;
            result.period_index = (last_match == kcpd_pkg::ACT_MODE) ?
                                  kcpd_pkg::PERIOD_LONG : kcpd_pkg::PERIOD_SHORT;
            hold_count_in       = '0;
         end
      end else if (hold_count_ff != '0) begin
         // Release: report the highest threshold the hold went past.
         if (above_first) begin
            result.detected     = 1'b1;
            result.action_id    = current_action_ff;
            result.period_index = above_long ? kcpd_pkg::PERIOD_LONG : kcpd_pkg::PERIOD_SHORT;
         end
         hold_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff     <= '0;
         current_action_ff <= kcpd_pkg::ACT_MODE;
         dead_time_left_ff <= '0;
      end else if (step) begin
         hold_count_ff     <= hold_count_in;
         current_action_ff <= current_action_in;
         dead_time_left_ff <= dead_time_left_in;
      end
   end

`ifndef SYNTHESIS
   a_hit_clears_count: assert property (@(posedge clock) disable iff (reset)
      step && result.detected |=> hold_count_ff == '0)
      else $error("hold count not cleared after a detection");

   a_pause_loads: assert property (@(posedge clock) disable iff (reset)
      step && item.func == kcpd_pkg::FUNC_PAUSE |=>
         dead_time_left_ff == $past(item.pause_ticks) && hold_count_ff == '0)
      else $error("pause item did not load dead time");

   a_dead_time_holds: assert property (@(posedge clock) disable iff (reset)
      step && item.func == kcpd_pkg::FUNC_TICK && dead_time_left_ff != '0 |=>
         hold_count_ff == $past(hold_count_ff) &&
         current_action_ff == $past(current_action_ff))
      else $error("tick during dead time changed the hold state");
`endif

endmodule

`default_nettype wire

// ===== hdl/key_combo_press_duration_classifier.sv =====
// ---------------------------------------------------------------------------
// Key combo press duration classifier
// Recognizes short and long holds of configured key combos, one tick item
// at a time, with a dead time started by pause items.
// ---------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)           tuser
//  req      in         key_mask[15:0], pause[31:16]  func
//  rsp      out        action_id[1:0], period[2]     detected
//  csr      in         csr_addr = index, csr_wdata   -
//
// Every item gives exactly one result item. An item is held in the input
// register and is classified on its way into the result register. One
// item is taken per cycle while the result register is not stalled; the
// hold state update between the two registers sets that rate. While the
// result register is stalled, one more item is taken into the input
// register. Reset is synchronous and restores the register reset values.
// ---------------------------------------------------------------------------
`default_nettype none

module key_combo_press_duration_classifier #(
   parameter int MASK_BITS = kcpd_pkg::MASK_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [31:0]                     req_tdata,  // key_mask, pause_ticks
   input  wire logic                            req_tuser,  // func
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,  // action_id, period_index, zeros
   output logic                                 rsp_tuser,  // detected
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [kcpd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [kcpd_pkg::TICK_W-1:0]     csr_wdata
);

   logic [kcpd_pkg::NUM_ACTIONS-1:0][MASK_BITS-1:0] combo_mask;
   kcpd_pkg::thresh_type                            thresh;

   logic                 in_valid_ff, in_valid_in;
   kcpd_pkg::item_type   in_item_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   kcpd_pkg::result_type rsp_ff;
   kcpd_pkg::result_type result;
   logic                 out_free;
   logic                 step;
   logic                 req_take;

   kcpd_csr #(.MASK_BITS(MASK_BITS)) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .combo_mask (combo_mask),
      .thresh     (thresh)
   );

   kcpd_core #(.MASK_BITS(MASK_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .combo_mask (combo_mask),
      .thresh     (thresh),
      .result     (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func        <= kcpd_pkg::func_type'(req_tuser);
         in_item_ff.key_mask    <= req_tdata[15:0];
         in_item_ff.pause_ticks <= req_tdata[31:16];
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.detected;
   assign rsp_tdata  = {5'd0, rsp_ff.period_index, rsp_ff.action_id};

`ifndef SYNTHESIS
   a_ready_only_stalls_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input refused while the pipeline had room");
`endif

endmodule

`default_nettype wire

// ===== sim/key_combo_press_duration_classifier_tb.sv =====
// ---------------------------------------------------------------------------
// Key combo press duration classifier testbench
// Drives tick and pause items into the classifier, keeps its own model of
// hold counting, dead time and combo matching, and compares every result
// item field by field. Directed tests cover reset values, short and long
// presses, equal combos, pauses and thresholds lowered during a hold; the
// random part holds the configured combos for lengths near the thresholds,
// mixed with pauses and noise masks, under several configurations.
// ---------------------------------------------------------------------------
`default_nettype none

module key_combo_press_duration_classifier_tb;
   import kcpd_pkg::*;

   localparam int MASK_BITS = MASK_BITS_DEFAULT;
   localparam logic [KEY_W-1:0] KEY_SEL = {KEY_W{1'b1}} >> (KEY_W - MASK_BITS);
   localparam int QUIET_LIMIT = 4000;
   localparam int NUM_PHASES = 12;
   localparam int PHASE_ITEMS = 110;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;  // key_mask, pause_ticks
   logic req_tuser = 1'b0;       // func
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // action_id, period_index, zeros
   logic rsp_tuser;              // detected
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [TICK_W-1:0] csr_wdata = '0;

   // Model state of the classifier.
   logic [TICK_W-1:0] reg_file [0:6];
   logic [TICK_W-1:0] hold_ticks;
   action_type held_action;
   logic [TICK_W-1:0] dead_ticks;

   result_type expected_results [$];
   int err_count = 0;
   int quiet_cycles = 0;
   bit no_idle = 1'b0;

   key_combo_press_duration_classifier #(
      .MASK_BITS(MASK_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [TICK_W-1:0] hold_limit(action_type act, int k);
      case (act)
         ACT_MODE: hold_limit = (k == 0) ? reg_file[REG_MODE_SHORT] : reg_file[REG_MODE_LONG];
         ACT_SELL: hold_limit = reg_file[REG_SELL_HOLD];
         default:  hold_limit = reg_file[REG_TEST_HOLD];
      endcase
   endfunction

   // Updates the model state for one item and returns its result.
   function automatic result_type classify_item(item_type it);
      result_type r;
      logic [KEY_W-1:0] keys;
      logic matched;
      int n;
      int k;
      int a;
      r = '0;
      matched = 1'b0;
      keys = it.key_mask & KEY_SEL;
      if (it.func == FUNC_PAUSE) begin
         hold_ticks = '0;
         dead_ticks = it.pause_ticks;
      end else if (dead_ticks != '0) begin
         dead_ticks = dead_ticks - 1'b1;
      end else begin
         // Combos are tried in order; a change of action restarts the count.
         for (a = 0; a < NUM_ACTIONS; a++) begin
            if (keys == (reg_file[a] & KEY_SEL)) begin
               if (held_action != action_type'(a)) begin
                  held_action = action_type'(a);
                  hold_ticks = '0;
               end
               matched = 1'b1;
               hold_ticks = hold_ticks + 1'b1;
            end
         end
         n = (held_action == ACT_MODE) ? 2 : 1;
         if (matched) begin
            if (hold_ticks >= hold_limit(held_action, n - 1)) begin
               r.detected = 1'b1;
               r.action_id = held_action;
               r.period_index = (n == 2) ? PERIOD_LONG : PERIOD_SHORT;
               hold_ticks = '0;
            end
         end else if (hold_ticks != '0) begin
            // On release the period is the number of thresholds passed, minus one.
            k = 0;
            while (k < n && hold_limit(held_action, k) < hold_ticks)
               k++;
            if (k != 0) begin
               r.detected = 1'b1;
               r.action_id = held_action;
               r.period_index = (k == 2) ? PERIOD_LONG : PERIOD_SHORT;
            end
            hold_ticks = '0;
         end
      end
      return r;
   endfunction

   task automatic send_item(item_type it);
      if (!no_idle && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {it.pause_ticks, it.key_mask};
      req_tuser <= it.func;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(classify_item(it));
   endtask

   task automatic send_tick(logic [KEY_W-1:0] keys);
      item_type it;
      it.func = FUNC_TICK;
      it.key_mask = keys;
      it.pause_ticks = TICK_W'($urandom);
      send_item(it);
   endtask

   task automatic send_pause(logic [TICK_W-1:0] ticks);
      item_type it;
      it.func = FUNC_PAUSE;
      it.key_mask = KEY_W'($urandom);
      it.pause_ticks = ticks;
      send_item(it);
   endtask

   // Stops the sender until every expected result item has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The valid stays high between writes of one batch; the last write lowers it.
   task automatic write_csr(csr_index_type idx, logic [TICK_W-1:0] val, bit last);
      csr_valid <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      reg_file[idx] = val;
      if (last)
         csr_valid <= 1'b0;
   endtask

   task automatic write_all_csrs(logic [TICK_W-1:0] vals [0:6]);
      int i;
      for (i = 0; i < 7; i++)
         write_csr(csr_index_type'(i), vals[i], i == 6);
   endtask

   task automatic test_reset_defaults();
      send_tick(16'h0001);
      send_tick(16'h0001);
      send_tick(16'h0000);
      send_tick(16'hFFFF);
   endtask

   task automatic test_short_long_press();
      wait_drained();
      write_csr(REG_MODE_SHORT, 16'd1, 1'b0);
      write_csr(REG_MODE_LONG, 16'd3, 1'b0);
      write_csr(REG_SELL_HOLD, 16'd2, 1'b0);
      write_csr(REG_TEST_HOLD, 16'd1, 1'b1);
      send_tick(16'h0001);
      send_tick(16'h0001);
      send_tick(16'h0000);
      repeat (3) send_tick(16'h0001);
   endtask

   task automatic test_sell_and_test();
      send_tick(16'h0002);
      send_tick(16'h0002);
      send_tick(16'h0003);
      send_tick(16'h0002);
      send_tick(16'h0003);
   endtask

   // With equal combos the last matching one wins and restarts the count.
   task automatic test_equal_combos();
      wait_drained();
      write_csr(REG_MODE_COMBO, 16'hFFFF, 1'b0);
      write_csr(REG_SELL_COMBO, 16'hFFFF, 1'b0);
      write_csr(REG_TEST_COMBO, 16'h0000, 1'b1);
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
      send_tick(16'h0000);
   endtask

   task automatic test_pause();
      wait_drained();
      write_csr(REG_MODE_COMBO, 16'h0001, 1'b0);
      write_csr(REG_SELL_COMBO, 16'h0002, 1'b0);
      write_csr(REG_TEST_COMBO, 16'h0003, 1'b1);
      send_tick(16'h0001);
      send_pause(16'hFFFF);
      send_pause(16'd2);
      repeat (4) send_tick(16'h0001);
      send_pause(16'd0);
      send_tick(16'h0000);
      wait_drained();
   endtask

   // Thresholds lowered while a hold is in progress show up on release.
   task automatic test_lowered_thresholds();
      write_csr(REG_SELL_HOLD, 16'd5, 1'b1);
      repeat (3) send_tick(16'h0002);
      wait_drained();
      write_csr(REG_SELL_HOLD, 16'd1, 1'b1);
      send_tick(16'h0000);
      wait_drained();
      write_csr(REG_MODE_LONG, 16'd10, 1'b1);
      repeat (4) send_tick(16'h0001);
      wait_drained();
      write_csr(REG_MODE_LONG, 16'd2, 1'b1);
      send_tick(16'h0000);
      wait_drained();
      write_csr(REG_TEST_HOLD, 16'd6, 1'b1);
      repeat (2) send_tick(16'h0003);
      wait_drained();
      write_csr(REG_TEST_HOLD, 16'd1, 1'b1);
      send_tick(16'h0000);
   endtask

   function automatic logic [TICK_W-1:0] pick_threshold();
      case ($urandom_range(0, 19))
         0:       pick_threshold = 16'hFFFF;
         1:       pick_threshold = 16'd1;
         2:       pick_threshold = TICK_W'($urandom_range(1, 65535));
         default: pick_threshold = TICK_W'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] pick_combo();
      case ($urandom_range(0, 9))
         0:       pick_combo = 16'h0000;
         1:       pick_combo = 16'hFFFF;
         2, 3, 4: pick_combo = 16'h0001 << $urandom_range(0, KEY_W - 1);
         default: pick_combo = KEY_W'($urandom);
      endcase
   endfunction

   task automatic set_phase_config(int phase);
      logic [TICK_W-1:0] vals [0:6];
      int i;
      for (i = 0; i < 3; i++) begin
         vals[i] = pick_combo();
         // Now and then a combo repeats an earlier one.
         if (i > 0 && $urandom_range(0, 5) == 0)
            vals[i] = vals[$urandom_range(0, i - 1)];
      end
      for (i = 3; i < 7; i++)
         vals[i] = pick_threshold();
      if (phase == 1) begin
         vals[REG_MODE_COMBO] = 16'h0000;
         vals[REG_SELL_COMBO] = 16'hFFFF;
         vals[REG_MODE_SHORT] = 16'd1;
         vals[REG_MODE_LONG] = 16'hFFFF;
         vals[REG_SELL_HOLD] = 16'd1;
         vals[REG_TEST_HOLD] = 16'hFFFF;
      end else if (phase == 2) begin
         vals[REG_MODE_SHORT] = 16'hFFFF;
         vals[REG_MODE_LONG] = 16'd1;
         vals[REG_TEST_COMBO] = 16'hFFFF;
      end
      wait_drained();
      write_all_csrs(vals);
   endtask

   task automatic run_random_holds(int n_items);
      int sent;
      int len;
      int lim;
      int pick;
      action_type act;
      logic [TICK_W-1:0] top;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            act = action_type'($urandom_range(0, 2));
            top = hold_limit(act, (act == ACT_MODE) ? 1 : 0);
            if (act == ACT_MODE && reg_file[REG_MODE_SHORT] > top)
               top = reg_file[REG_MODE_SHORT];
            lim = (top > 46) ? 48 : int'(top) + 2;
            len = $urandom_range(1, lim);
            repeat (len) send_tick(reg_file[act] & KEY_SEL);
            sent += len;
            if ($urandom_range(0, 4) != 0) begin
               send_tick(KEY_W'($urandom));
               sent++;
            end
         end else if (pick < 80) begin
            send_pause(TICK_W'($urandom_range(0, 8)));
            sent++;
         end else if (pick < 85) begin
            // A long dead time is cut short by a following short pause.
            send_pause(TICK_W'($urandom));
            send_pause(TICK_W'($urandom_range(0, 3)));
            sent += 2;
         end else begin
            send_tick(KEY_W'($urandom));
            sent++;
         end
         if (sent > n_items / 2 && sent <= n_items / 2 + 3)
            wait_drained();
      end
   endtask

   task automatic test_random_holds();
      int phase;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == NUM_PHASES - 1)
            no_idle = 1'b1;
         set_phase_config(phase);
         run_random_holds(PHASE_ITEMS);
      end
   endtask

   // Receiver stalls in random bursts until the last part of the run.
   initial begin
      @(posedge clock);
      forever begin
         if (no_idle) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result item with none expected: detected %0d action_id %0d period_index %0d",
                   rsp_tuser, rsp_tdata[1:0], rsp_tdata[2]);
            err_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.detected) begin
               $error("detected: expected %0d, actual %0d", want.detected, rsp_tuser);
               err_count++;
            end
            if (rsp_tdata[1:0] !== want.action_id) begin
               $error("action_id: expected %0d, actual %0d", want.action_id, rsp_tdata[1:0]);
               err_count++;
            end
            if (rsp_tdata[2] !== want.period_index) begin
               $error("period_index: expected %0d, actual %0d", want.period_index, rsp_tdata[2]);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reg_file[REG_MODE_COMBO] = MODE_COMBO_RESET;
      reg_file[REG_SELL_COMBO] = SELL_COMBO_RESET;
      reg_file[REG_TEST_COMBO] = TEST_COMBO_RESET;
      reg_file[REG_MODE_SHORT] = MODE_SHORT_RESET;
      reg_file[REG_MODE_LONG] = MODE_LONG_RESET;
      reg_file[REG_SELL_HOLD] = SELL_HOLD_RESET;
      reg_file[REG_TEST_HOLD] = TEST_HOLD_RESET;
      hold_ticks = '0;
      held_action = ACT_MODE;
      dead_ticks = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_short_long_press();
      test_sell_and_test();
      test_equal_combos();
      test_pause();
      test_lowered_thresholds();
      test_random_holds();
      wait_drained();
      repeat (6) @(posedge clock);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
